### hw/rtl/reliable_link_receive_step_core_macros.svh
// Assertion macros shared by the link receive checker.
// No dependencies; include once per file that asserts.
`ifndef RELIABLE_LINK_RECEIVE_STEP_CORE_MACROS_SVH
`define RELIABLE_LINK_RECEIVE_STEP_CORE_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define RLRS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, off while reset is low.
`define RLRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also watches reset itself.
`define RLRS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/rlrs_pkg.sv
// Types, codes and constants of the link receive step core.
// No dependencies; imported by every module of the block.
`default_nettype none

package rlrs_pkg;

  localparam int TIME_BITS = 32;
  localparam int SEQ_BITS  = 8;
  localparam int PORT_TIME_BITS = 32;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_DATA = 2'd1,
    CMD_ACK  = 2'd2,
    CMD_NAK  = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HOST_WINDOW    = 3'd0,
    CFG_CLIENT_BUFFERS = 3'd1,
    CFG_SSTHRESH       = 3'd2,
    CFG_DELAYED_ACK    = 3'd3,
    CFG_ENCRYPTION     = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]  host_window;
    logic [7:0]  client_buffers;
    logic [7:0]  ssthresh;
    logic [15:0] delayed_ack_ms;
    logic        encryption_on;
  } cfg_t;

  // Classified frame header, as it travels through the queue.
  typedef struct packed {
    cmd_t                 cmd;
    logic                 rst_apply;
    logic [SEQ_BITS-1:0]  seq;
    logic                 piggy_valid;
    logic [SEQ_BITS-1:0]  piggy_seq;
    logic                 ack_now;
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] delayed;
  } item_t;

  typedef struct packed {
    logic                      deliver;
    logic                      free_valid;
    logic [SEQ_BITS-1:0]       free_upto_seq;
    logic                      send_reset;
    logic [PORT_TIME_BITS-1:0] ack_deadline;
    logic [PORT_TIME_BITS-1:0] nak_deadline;
    logic [PORT_TIME_BITS-1:0] retransmit_deadline;
    logic                      retransmit_by_nak;
    logic [7:0]                window_now;
    logic [SEQ_BITS-1:0]       expected_now;
    logic [SEQ_BITS-1:0]       last_nak;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/reliable_link_receive_step_core.sv
// Receive step of a sliding-window link with slow-start congestion window.
// Each beat on the in_ channel is one received frame header; each beat on
// the out_ channel is the matching result: delivery, buffer release, reset
// reply, the three timer deadlines and the link state after the frame.
// Exactly one result beat follows every input beat, in order.
// A header accepted on the in_ channel is written into the queue, then
// applied by the back end and held in its result register. Throughput: one
// beat per cycle while out_ready stays high, set by the back end's single
// state update per cycle.
// A two-entry queue sits between the classifying front end and the state
// back end; when out_ready is low the result register holds, the queue
// fills, and in_ready drops once both queue entries are taken.
// cfg_we writes one register per cycle; write only while no beat is in
// flight. Synchronous reset (rst_n low) empties the queue, drops
// out_valid, restores register defaults and the link state.
// Depends on rlrs_pkg, rlrs_front, rlrs_queue and rlrs_back.
`default_nettype none

module reliable_link_receive_step_core import rlrs_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_cmd,
  input  wire logic                      in_reset_flag,
  input  wire logic [SEQ_BITS-1:0]       in_sequence_req,
  input  wire logic                      in_piggy_ack_valid,
  input  wire logic [SEQ_BITS-1:0]       in_piggy_ack_seq,
  input  wire logic                      in_payload_nonempty,
  input  wire logic                      in_ack_now,
  input  wire logic [31:0]               in_now_ms,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_deliver,
  output logic                           out_free_valid,
  output logic [SEQ_BITS-1:0]            out_free_upto_seq,
  output logic                           out_send_reset,
  output logic [PORT_TIME_BITS-1:0]      out_ack_deadline,
  output logic [PORT_TIME_BITS-1:0]      out_nak_deadline,
  output logic [PORT_TIME_BITS-1:0]      out_retransmit_deadline,
  output logic                           out_retransmit_by_nak,
  output logic [7:0]                     out_window_now,
  output logic [SEQ_BITS-1:0]            out_expected_now,
  output logic [SEQ_BITS-1:0]            out_last_nak
);

  cfg_t    cfg_r;
  item_t   front_item;
  item_t   q_head;
  logic    q_full;
  logic    q_not_empty;
  logic    q_pop;
  logic    push;
  result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.host_window    <= 8'd8;
      cfg_r.client_buffers <= 8'd8;
      cfg_r.ssthresh       <= 8'd4;
      cfg_r.delayed_ack_ms <= 16'd100;
      cfg_r.encryption_on  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HOST_WINDOW:    cfg_r.host_window    <= cfg_wdata[7:0];
        CFG_CLIENT_BUFFERS: cfg_r.client_buffers <= cfg_wdata[7:0];
        CFG_SSTHRESH:       cfg_r.ssthresh       <= cfg_wdata[7:0];
        CFG_DELAYED_ACK:    cfg_r.delayed_ack_ms <= cfg_wdata;
        CFG_ENCRYPTION:     cfg_r.encryption_on  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  rlrs_front u_front (
    .cfg              (cfg_r),
    .cmd              (in_cmd),
    .reset_flag       (in_reset_flag),
    .sequence_req     (in_sequence_req),
    .piggy_ack_valid  (in_piggy_ack_valid),
    .piggy_ack_seq    (in_piggy_ack_seq),
    .payload_nonempty (in_payload_nonempty),
    .ack_now          (in_ack_now),
    .now_ms           (in_now_ms),
    .item             (front_item)
  );

  rlrs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  rlrs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (q_not_empty),
    .item       (q_head),
    .item_pop   (q_pop),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign out_deliver             = res.deliver;
  assign out_free_valid          = res.free_valid;
  assign out_free_upto_seq       = res.free_upto_seq;
  assign out_send_reset          = res.send_reset;
  assign out_ack_deadline        = res.ack_deadline;
  assign out_nak_deadline        = res.nak_deadline;
  assign out_retransmit_deadline = res.retransmit_deadline;
  assign out_retransmit_by_nak   = res.retransmit_by_nak;
  assign out_window_now          = res.window_now;
  assign out_expected_now        = res.expected_now;
  assign out_last_nak            = res.last_nak;

endmodule

`default_nettype wire

### hw/rtl/rlrs_front.sv
// Front end: classifies an incoming frame header into a queue entry.
// Depends on rlrs_pkg.
`default_nettype none

module rlrs_front import rlrs_pkg::*; (
  input  wire cfg_t                 cfg,
  input  wire logic [1:0]           cmd,
  input  wire logic                 reset_flag,
  input  wire logic [SEQ_BITS-1:0]  sequence_req,
  input  wire logic                 piggy_ack_valid,
  input  wire logic [SEQ_BITS-1:0]  piggy_ack_seq,
  input  wire logic                 payload_nonempty,
  input  wire logic                 ack_now,
  input  wire logic [31:0]          now_ms,
  output item_t                     item
);

  logic [TIME_BITS-1:0] now_t;

  assign now_t = TIME_BITS'(now_ms);

  always_comb begin
    item.cmd         = cmd_t'(cmd);
    // an encrypted link refuses a reset that carries payload
    item.rst_apply   = reset_flag && (!payload_nonempty || !cfg.encryption_on);
    item.seq         = sequence_req;
    item.piggy_valid = (cmd_t'(cmd) == CMD_DATA) && piggy_ack_valid;
    item.piggy_seq   = piggy_ack_seq;
    item.ack_now     = ack_now;
    item.now         = now_t;
    item.delayed     = now_t + TIME_BITS'(cfg.delayed_ack_ms);
  end

endmodule

`default_nettype wire

### hw/rtl/rlrs_queue.sv
// Short queue between the front end and the back end.
// Depends on rlrs_pkg.
`default_nettype none

module rlrs_queue import rlrs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  pop,
  output logic       not_empty,
  output item_t      head
);

  item_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = QCNT_W'(count_r + QCNT_W'(push) - QCNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rlrs_back.sv
// Back end: applies one queued header to the link state and registers the result.
// Depends on rlrs_pkg.
`default_nettype none

module rlrs_back import rlrs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire cfg_t  cfg,
  input  wire logic  item_valid,
  input  wire item_t item,
  output logic       item_pop,
  output logic       res_valid,
  input  wire logic  res_ready,
  output result_t    res
);

  logic [SEQ_BITS-1:0]  expected_r, expected_nxt;
  logic                 nak_sent_r, nak_sent_nxt;
  logic [TIME_BITS-1:0] nak_timer_r, nak_timer_nxt;
  logic [TIME_BITS-1:0] ack_timer_r, ack_timer_nxt;
  logic [TIME_BITS-1:0] rtx_timer_r, rtx_timer_nxt;
  logic                 nak_rtx_r, nak_rtx_nxt;
  logic [SEQ_BITS-1:0]  last_nak_r, last_nak_nxt;
  logic [7:0]           cwnd_r, cwnd_nxt;
  logic [7:0]           ccount_r, ccount_nxt;
  logic                 res_valid_r;
  result_t              res_r, res_nxt;

  logic [SEQ_BITS-1:0]  exp_base;
  logic [SEQ_BITS-1:0]  diff;
  logic [7:0]           ccount_inc;
  logic                 grow;

  assign item_pop  = item_valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    exp_base      = item.rst_apply ? '0 : expected_r;
    diff          = SEQ_BITS'(exp_base - item.seq);
    ccount_inc    = 8'(ccount_r + 8'd1);
    grow          = 1'b0;

    expected_nxt  = exp_base;
    nak_sent_nxt  = nak_sent_r;
    nak_timer_nxt = nak_timer_r;
    ack_timer_nxt = ack_timer_r;
    rtx_timer_nxt = rtx_timer_r;
    nak_rtx_nxt   = nak_rtx_r;
    last_nak_nxt  = last_nak_r;
    cwnd_nxt      = cwnd_r;
    ccount_nxt    = ccount_r;

    res_nxt               = '0;
    res_nxt.send_reset    = item.rst_apply;

    unique case (item.cmd)
      CMD_DATA: begin
        if (item.piggy_valid) begin
          res_nxt.free_valid    = 1'b1;
          res_nxt.free_upto_seq = item.piggy_seq;
          grow                  = 1'b1;
        end
        if (diff != '0) begin
          if (diff > cfg.host_window) begin
            // frame lost ahead of us: arm the nak once
            if (!nak_sent_r) begin
              nak_sent_nxt  = 1'b1;
              nak_timer_nxt = item.now;
            end
          end else if (ack_timer_r == '0) begin
            ack_timer_nxt = item.delayed;
          end
        end else begin
          expected_nxt    = SEQ_BITS'(exp_base + 1'b1);
          nak_sent_nxt    = 1'b0;
          nak_timer_nxt   = '0;
          if (item.ack_now) begin
            ack_timer_nxt = item.now;
          end else if (ack_timer_r == '0) begin
            ack_timer_nxt = item.delayed;
          end
          res_nxt.deliver = 1'b1;
        end
      end
      CMD_ACK: begin
        res_nxt.free_valid    = 1'b1;
        res_nxt.free_upto_seq = item.seq;
        grow                  = 1'b1;
      end
      CMD_NAK: begin
        res_nxt.free_valid    = 1'b1;
        res_nxt.free_upto_seq = SEQ_BITS'(item.seq - 1'b1);
        nak_rtx_nxt           = 1'b1;
        last_nak_nxt          = item.seq;
        rtx_timer_nxt         = item.now;
      end
      CMD_NONE: begin
      end
      default: begin
      end
    endcase

    // slow start below threshold, avoidance above, never past the buffer count
    if (grow && (cwnd_r < cfg.client_buffers)) begin
      if (cwnd_r < cfg.ssthresh) begin
        cwnd_nxt = 8'(cwnd_r + 8'd1);
      end else if (ccount_inc > cwnd_r) begin
        cwnd_nxt   = 8'(cwnd_r + 8'd1);
        ccount_nxt = '0;
      end else begin
        ccount_nxt = ccount_inc;
      end
    end

    res_nxt.ack_deadline        = PORT_TIME_BITS'(ack_timer_nxt);
    res_nxt.nak_deadline        = PORT_TIME_BITS'(nak_timer_nxt);
    res_nxt.retransmit_deadline = PORT_TIME_BITS'(rtx_timer_nxt);
    res_nxt.retransmit_by_nak   = nak_rtx_nxt;
    res_nxt.window_now          = cwnd_nxt;
    res_nxt.expected_now        = expected_nxt;
    res_nxt.last_nak            = last_nak_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_r  <= '0;
      nak_sent_r  <= 1'b0;
      nak_timer_r <= '0;
      ack_timer_r <= '0;
      rtx_timer_r <= '0;
      nak_rtx_r   <= 1'b0;
      last_nak_r  <= '0;
      cwnd_r      <= 8'd1;
      ccount_r    <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (item_pop) begin
        expected_r  <= expected_nxt;
        nak_sent_r  <= nak_sent_nxt;
        nak_timer_r <= nak_timer_nxt;
        ack_timer_r <= ack_timer_nxt;
        rtx_timer_r <= rtx_timer_nxt;
        nak_rtx_r   <= nak_rtx_nxt;
        last_nak_r  <= last_nak_nxt;
        cwnd_r      <= cwnd_nxt;
        ccount_r    <= ccount_nxt;
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rlrs_checker.sv
// Port-level checker for the link receive step core, bound to the top level.
// Depends on rlrs_pkg and reliable_link_receive_step_core_macros.svh.
`default_nettype none
`include "reliable_link_receive_step_core_macros.svh"

module rlrs_checker import rlrs_pkg::*; (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic                      out_deliver,
  input wire logic [PORT_TIME_BITS-1:0] out_ack_deadline,
  input wire logic [PORT_TIME_BITS-1:0] out_nak_deadline,
  input wire logic                      out_retransmit_by_nak,
  input wire logic [7:0]                out_window_now,
  input wire logic [SEQ_BITS-1:0]       out_expected_now
);

  // a stalled result beat holds
  `RLRS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_expected_now) && $stable(out_ack_deadline) && $stable(out_deliver))

  // reset drops the result channel
  `RLRS_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid)

  // an in-order delivery always disarms the nak timer
  `RLRS_ASSERT_NOW(a_deliver_nak, clk, rst_n, out_valid && out_deliver, out_nak_deadline == '0)

  // the congestion window never collapses to zero
  `RLRS_ASSERT_NOW(a_window_nz, clk, rst_n, out_valid, out_window_now != 8'd0)

  // the nak retransmit flag is sticky across beats
  `RLRS_ASSERT_NEXT(a_rtx_sticky, clk, rst_n, out_valid && out_ready && out_retransmit_by_nak, !out_valid || out_retransmit_by_nak)

endmodule

bind reliable_link_receive_step_core rlrs_checker u_rlrs_checker (.*);

`default_nettype wire

### tb/reliable_link_receive_step_core_checker.sv
// Scoreboard for the link receive step core: follows the config port and both
// beat channels, predicts every result beat and compares it field by field.
// Depends on rlrs_pkg for the command, register index and result types.
module reliable_link_receive_step_core_checker import rlrs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [1:0]            in_cmd,
  input  logic                  in_reset_flag,
  input  logic [SEQ_BITS-1:0]   in_sequence_req,
  input  logic                  in_piggy_ack_valid,
  input  logic [SEQ_BITS-1:0]   in_piggy_ack_seq,
  input  logic                  in_payload_nonempty,
  input  logic                  in_ack_now,
  input  logic [31:0]           in_now_ms,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_deliver,
  input  logic                  out_free_valid,
  input  logic [SEQ_BITS-1:0]   out_free_upto_seq,
  input  logic                  out_send_reset,
  input  logic [31:0]           out_ack_deadline,
  input  logic [31:0]           out_nak_deadline,
  input  logic [31:0]           out_retransmit_deadline,
  input  logic                  out_retransmit_by_nak,
  input  logic [7:0]            out_window_now,
  input  logic [SEQ_BITS-1:0]   out_expected_now,
  input  logic [SEQ_BITS-1:0]   out_last_nak,
  output int                    errors,
  output int                    pending,
  output logic [SEQ_BITS-1:0]   seq_expected
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copies.
  logic [7:0]          host_window;
  logic [7:0]          client_buffers;
  logic [7:0]          ssthresh;
  logic [15:0]         ack_delay;
  logic                crypt_on;

  // Link state.
  logic [SEQ_BITS-1:0] rx_expected;
  logic                nak_armed;
  logic [31:0]         nak_timer;
  logic [31:0]         ack_timer;
  logic [31:0]         rexmit_timer;
  logic                rexmit_by_nak;
  logic [SEQ_BITS-1:0] last_nak_seq;
  logic [7:0]          cwnd;
  logic [7:0]          cwnd_count;

  result_t             step_results[$];
  int                  fail_count = 0;
  int                  queued = 0;
  int                  beat_count = 0;

  assign errors       = fail_count;
  assign pending      = queued;
  assign seq_expected = rx_expected;

  task automatic restore_link();
    host_window    = 8'd8;
    client_buffers = 8'd8;
    ssthresh       = 8'd4;
    ack_delay      = 16'd100;
    crypt_on       = 1'b0;
    rx_expected    = '0;
    nak_armed      = 1'b0;
    nak_timer      = '0;
    ack_timer      = '0;
    rexmit_timer   = '0;
    rexmit_by_nak  = 1'b0;
    last_nak_seq   = '0;
    cwnd           = 8'd1;
    cwnd_count     = '0;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_HOST_WINDOW:    host_window    = data[7:0];
      CFG_CLIENT_BUFFERS: client_buffers = data[7:0];
      CFG_SSTHRESH:       ssthresh       = data[7:0];
      CFG_DELAYED_ACK:    ack_delay      = data[15:0];
      CFG_ENCRYPTION:     crypt_on       = data[0];
      default: ;
    endcase
  endtask

  // Slow start below the threshold, then one step per window's worth of acks.
  task automatic grow_window();
    if (cwnd < client_buffers) begin
      if (cwnd < ssthresh) begin
        cwnd = cwnd + 8'd1;
      end else begin
        cwnd_count = cwnd_count + 8'd1;
        if (cwnd_count > cwnd) begin
          cwnd       = cwnd + 8'd1;
          cwnd_count = '0;
        end
      end
    end
  endtask

  task automatic receive_frame(input cmd_t cmd, input logic rst_flag,
                               input logic [SEQ_BITS-1:0] seq, input logic piggy,
                               input logic [SEQ_BITS-1:0] piggy_seq,
                               input logic nonempty, input logic ack_now,
                               input logic [31:0] now, output result_t res);
    logic [31:0]         delayed;
    logic [SEQ_BITS-1:0] gap;
    res     = '0;
    delayed = now + {16'd0, ack_delay};
    // Reset applies before the frame itself is looked at.
    if (rst_flag && (!nonempty || !crypt_on)) begin
      rx_expected    = '0;
      res.send_reset = 1'b1;
    end
    case (cmd)
      CMD_DATA: begin
        if (piggy) begin
          res.free_valid    = 1'b1;
          res.free_upto_seq = piggy_seq;
          grow_window();
        end
        gap = rx_expected - seq;
        if (gap == '0) begin
          rx_expected = rx_expected + 1'b1;
          nak_armed   = 1'b0;
          nak_timer   = '0;
          if (ack_now) ack_timer = now;
          else if (ack_timer == '0) ack_timer = delayed;
          res.deliver = 1'b1;
        end else if (gap > host_window) begin
          // Lost frame: arm the nak once per gap.
          if (!nak_armed) begin
            nak_armed = 1'b1;
            nak_timer = now;
          end
        end else if (ack_timer == '0) begin
          ack_timer = delayed;
        end
      end
      CMD_ACK: begin
        res.free_valid    = 1'b1;
        res.free_upto_seq = seq;
        grow_window();
      end
      CMD_NAK: begin
        res.free_valid    = 1'b1;
        res.free_upto_seq = seq - 1'b1;
        rexmit_by_nak     = 1'b1;
        last_nak_seq      = seq;
        rexmit_timer      = now;
      end
      default: ;
    endcase
    res.ack_deadline        = ack_timer;
    res.nak_deadline        = nak_timer;
    res.retransmit_deadline = rexmit_timer;
    res.retransmit_by_nak   = rexmit_by_nak;
    res.window_now          = cwnd;
    res.expected_now        = rx_expected;
    res.last_nak            = last_nak_seq;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] result %0d %s: got 0x%0h, want 0x%0h", $time, beat_count, what, got,
             want);
    fail_count++;
  endtask

  task automatic check_result();
    result_t want;
    if (step_results.size() == 0) begin
      report("beat with no frame pending", 32'd1, 32'd0);
    end else begin
      want = step_results.pop_front();
      if (out_deliver !== want.deliver)
        report("deliver", 32'(out_deliver), 32'(want.deliver));
      if (out_free_valid !== want.free_valid)
        report("free_valid", 32'(out_free_valid), 32'(want.free_valid));
      if (out_free_upto_seq !== want.free_upto_seq)
        report("free_upto_seq", 32'(out_free_upto_seq), 32'(want.free_upto_seq));
      if (out_send_reset !== want.send_reset)
        report("send_reset", 32'(out_send_reset), 32'(want.send_reset));
      if (out_ack_deadline !== want.ack_deadline)
        report("ack_deadline", out_ack_deadline, want.ack_deadline);
      if (out_nak_deadline !== want.nak_deadline)
        report("nak_deadline", out_nak_deadline, want.nak_deadline);
      if (out_retransmit_deadline !== want.retransmit_deadline)
        report("retransmit_deadline", out_retransmit_deadline, want.retransmit_deadline);
      if (out_retransmit_by_nak !== want.retransmit_by_nak)
        report("retransmit_by_nak", 32'(out_retransmit_by_nak), 32'(want.retransmit_by_nak));
      if (out_window_now !== want.window_now)
        report("window_now", 32'(out_window_now), 32'(want.window_now));
      if (out_expected_now !== want.expected_now)
        report("expected_now", 32'(out_expected_now), 32'(want.expected_now));
      if (out_last_nak !== want.last_nak)
        report("last_nak", 32'(out_last_nak), 32'(want.last_nak));
    end
    beat_count++;
  endtask

  initial restore_link();

  always @(posedge clk) begin : track
    result_t res;
    if (!rst_n) begin
      restore_link();
      step_results.delete();
    end else begin
      if (cfg_we) write_reg(cfg_idx_t'(cfg_index), cfg_wdata);
      if (in_valid && in_ready) begin
        receive_frame(cmd_t'(in_cmd), in_reset_flag, in_sequence_req, in_piggy_ack_valid,
                      in_piggy_ack_seq, in_payload_nonempty, in_ack_now, in_now_ms, res);
        step_results.push_back(res);
      end
      if (out_valid && out_ready) check_result();
    end
    queued = step_results.size();
  end

endmodule

### tb/reliable_link_receive_step_core_tb.sv
// Top of the link receive step core bench: clock, reset, register setup, frame
// stimulus and the verdict. Depends on rlrs_pkg, the core and its checker.
module reliable_link_receive_step_core_tb import rlrs_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_HOST_WINDOW;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_cmd = CMD_NONE;
  logic                  in_reset_flag = 1'b0;
  logic [SEQ_BITS-1:0]   in_sequence_req = '0;
  logic                  in_piggy_ack_valid = 1'b0;
  logic [SEQ_BITS-1:0]   in_piggy_ack_seq = '0;
  logic                  in_payload_nonempty = 1'b0;
  logic                  in_ack_now = 1'b0;
  logic [31:0]           in_now_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic                  out_deliver;
  logic                  out_free_valid;
  logic [SEQ_BITS-1:0]   out_free_upto_seq;
  logic                  out_send_reset;
  logic [31:0]           out_ack_deadline;
  logic [31:0]           out_nak_deadline;
  logic [31:0]           out_retransmit_deadline;
  logic                  out_retransmit_by_nak;
  logic [7:0]            out_window_now;
  logic [SEQ_BITS-1:0]   out_expected_now;
  logic [SEQ_BITS-1:0]   out_last_nak;

  int                    errors;
  int                    pending;
  logic [SEQ_BITS-1:0]   seq_expected;

  int                    cycle_cnt = 0;
  int                    ready_hold = 0;
  logic                  src_steady = 1'b0;
  logic                  sink_steady = 1'b0;
  logic [31:0]           clock_ms = 32'd1000;

  reliable_link_receive_step_core u_top (.*);

  reliable_link_receive_step_core_checker u_checker (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result sink: short stalls mostly, now and then a long one or a steady run.
  always @(negedge clk) begin : sink
    int pick;
    pick = $urandom_range(0, 99);
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (sink_steady || pick < 55) begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 8);
    end else if (pick < 93) begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(0, 2);
    end else begin
      out_ready  <= 1'b0;
      ready_hold <= $urandom_range(10, 30);
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_frame(input cmd_t cmd, input logic rst_flag,
                            input logic [SEQ_BITS-1:0] seq, input logic piggy,
                            input logic [SEQ_BITS-1:0] piggy_seq, input logic nonempty,
                            input logic ack_now, input logic [31:0] now);
    in_valid            <= 1'b1;
    in_cmd              <= cmd;
    in_reset_flag       <= rst_flag;
    in_sequence_req     <= seq;
    in_piggy_ack_valid  <= piggy;
    in_piggy_ack_seq    <= piggy_seq;
    in_payload_nonempty <= nonempty;
    in_ack_now          <= ack_now;
    in_now_ms           <= now;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic pause_source();
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    if (src_steady || pick < 60) gap = 0;
    else if (pick < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drop valid and wait until every frame in flight has its result.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all five registers back to back; spare upper data bits get noise.
  task automatic program_regs(input logic [7:0] hw, input logic [7:0] cb,
                              input logic [7:0] ss, input logic [15:0] dly,
                              input logic enc);
    logic [15:0] vals [5];
    logic [15:0] keep;
    cfg_idx_t    idx;
    settle();
    vals = '{{8'd0, hw}, {8'd0, cb}, {8'd0, ss}, dly, {15'd0, enc}};
    for (int i = 0; i < 5; i++) begin
      idx = cfg_idx_t'(i);
      case (idx)
        CFG_DELAYED_ACK: keep = 16'hffff;
        CFG_ENCRYPTION:  keep = 16'h0001;
        default:         keep = 16'h00ff;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= (vals[i] & keep) | (16'($urandom) & ~keep);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_frame();
    int                  pick;
    cmd_t                cmd;
    logic [SEQ_BITS-1:0] seq;
    logic [31:0]         now;
    logic                nonempty;
    pick = $urandom_range(0, 99);
    if (pick < 55) cmd = CMD_DATA;
    else if (pick < 75) cmd = CMD_ACK;
    else if (pick < 90) cmd = CMD_NAK;
    else cmd = CMD_NONE;
    // Data frames mostly follow the link; the rest is duplicates, gaps and noise.
    pick = $urandom_range(0, 99);
    if (cmd != CMD_DATA || pick >= 90) seq = 8'($urandom);
    else if (pick < 65) seq = seq_expected;
    else if (pick < 80) seq = seq_expected - 8'($urandom_range(1, 10));
    else seq = seq_expected + 8'($urandom_range(1, 20));
    clock_ms = clock_ms + 32'($urandom_range(0, 250));
    pick = $urandom_range(0, 99);
    if (pick < 3) now = $urandom;
    else if (pick < 5) now = '0;
    else now = clock_ms;
    nonempty = (cmd == CMD_DATA) ? ($urandom_range(0, 9) != 0) : 1'($urandom);
    send_frame(cmd, $urandom_range(0, 24) == 0, seq, $urandom_range(0, 9) < 4,
               8'($urandom), nonempty, $urandom_range(0, 9) < 3, now);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0) src_steady = !src_steady;
      if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
      random_frame();
      pause_source();
    end
  endtask

  task automatic directed_frames();
    send_frame(CMD_NONE, 1'b0, 8'hff, 1'b1, 8'hff, 1'b1, 1'b1, 32'd1000);
    // In order, acked at once at time zero: deadline reads as disarmed.
    send_frame(CMD_DATA, 1'b0, 8'd0, 1'b0, 8'd0, 1'b1, 1'b1, 32'd0);
    // Delayed ack wraps past the top of the time range.
    send_frame(CMD_DATA, 1'b0, 8'd1, 1'b0, 8'd0, 1'b1, 1'b0, 32'hffff_ffc0);
    send_frame(CMD_DATA, 1'b0, 8'd200, 1'b0, 8'd0, 1'b1, 1'b0, 32'd5000);
    send_frame(CMD_DATA, 1'b0, 8'd201, 1'b0, 8'd0, 1'b1, 1'b0, 32'd5100);
    send_frame(CMD_DATA, 1'b0, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0, 32'd5200);
    send_frame(CMD_DATA, 1'b0, 8'd2, 1'b1, 8'd0, 1'b1, 1'b1, 32'd6000);
    // Piggyback flag on an ack frame does nothing.
    send_frame(CMD_ACK, 1'b0, 8'hff, 1'b1, 8'h55, 1'b0, 1'b0, 32'd6100);
    for (int i = 0; i < 6; i++)
      send_frame(CMD_ACK, 1'b0, 8'(i), 1'b0, 8'd0, 1'b0, 1'b0, 32'd6200);
    send_frame(CMD_NAK, 1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0, 32'hffff_ffff);
    send_frame(CMD_NAK, 1'b0, 8'hff, 1'b0, 8'd0, 1'b0, 1'b0, 32'd0);
    send_frame(CMD_NONE, 1'b1, 8'd7, 1'b0, 8'd0, 1'b1, 1'b0, 32'd7000);
    // Reset with data: checked against sequence zero.
    send_frame(CMD_DATA, 1'b1, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0, 32'd7100);
    send_frame(CMD_DATA, 1'b1, 8'd5, 1'b0, 8'd0, 1'b1, 1'b0, 32'd7200);
    send_frame(CMD_DATA, 1'b0, 8'd0, 1'b0, 8'd0, 1'b1, 1'b1, 32'd7300);
    // Encryption blocks a reset that carries payload.
    program_regs(8'd8, 8'd8, 8'd4, 16'd100, 1'b1);
    send_frame(CMD_NONE, 1'b1, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0, 32'd8000);
    send_frame(CMD_ACK, 1'b1, 8'd3, 1'b0, 8'd0, 1'b0, 1'b0, 32'd8100);
    // Zero host window: even a one-behind frame counts as lost.
    program_regs(8'd0, 8'd8, 8'd4, 16'd100, 1'b0);
    send_frame(CMD_DATA, 1'b0, seq_expected - 8'd1, 1'b0, 8'd0, 1'b1, 1'b0, 32'd9000);
    // Window above the lowered buffer count: no growth.
    program_regs(8'd8, 8'd1, 8'd4, 16'd100, 1'b0);
    send_frame(CMD_ACK, 1'b0, 8'd9, 1'b0, 8'd0, 1'b0, 1'b0, 32'd9100);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    directed_frames();

    program_regs(8'd8, 8'd8, 8'd4, 16'd100, 1'b0);
    run_random(225);
    program_regs(8'd0, 8'd255, 8'd0, 16'hffff, 1'b1);
    run_random(225);
    clock_ms = 32'hffff_f000;
    program_regs(8'd255, 8'd1, 8'd255, 16'd0, 1'b0);
    run_random(225);
    program_regs(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                 8'($urandom_range(0, 255)), 16'($urandom), 1'($urandom));
    run_random(225);

    settle();
    repeat (8) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
